// ----- rtl/mrlp_pkg.sv -----
package mrlp_pkg;

  // Width of the number accumulator; numbers wrap modulo 2**ValueBits.
  localparam int ValueBits = 32;

  // Width of the reply value port.
  localparam int ReplyBits = 32;

  // Parse phases.
  typedef enum logic [2:0] {
    PhIdle  = 3'd0,
    PhUnexp = 3'd1,
    PhNum   = 3'd2,
    PhAck   = 3'd3,
    PhText  = 3'd4,
    PhNote  = 3'd5,
    PhTerm  = 3'd6
  } phase_t;

  // Reply kinds.
  typedef enum logic [1:0] {
    KindAck  = 2'd0,
    KindNote = 2'd1,
    KindNum  = 2'd2,
    KindText = 2'd3
  } kind_t;

  // Configuration register indexes.
  localparam logic [1:0] CfgStartCtl = 2'd0;
  localparam logic [1:0] CfgStopCtl  = 2'd1;

  // Reset values of the flow-control bytes.
  localparam logic [7:0] StartCtlReset = 8'd17;
  localparam logic [7:0] StopCtlReset  = 8'd19;

  // Characters of the reply grammar.
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChO     = 8'h4F;
  localparam logic [7:0] ChK     = 8'h4B;
  localparam logic [7:0] ChMinus = 8'h2D;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    phase_t                 phase;
    kind_t                  pending_kind;
    logic [7:0]             notify_letter;
    logic [ValueBits-1:0]   magnitude;
    logic                   is_negative;
    logic                   resync_pending;
  } parse_state_t;

  // One completed reply.
  typedef struct packed {
    kind_t                  kind;
    logic [ReplyBits-1:0]   value;
    logic                   lost;
  } reply_t;

endpackage

// ----- rtl/mrlp_step.sv -----
module mrlp_step (
  input  mrlp_pkg::parse_state_t cur,
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             start_ctl_byte,
  input  logic [7:0]             stop_ctl_byte,
  output mrlp_pkg::parse_state_t nxt,
  output logic                   done,
  output mrlp_pkg::reply_t       reply
);
  import mrlp_pkg::*;

  logic                 is_digit;
  logic                 is_alpha;
  logic                 is_note;
  logic                 is_ctl;
  logic [ValueBits-1:0] mag_base;
  logic [ValueBits-1:0] mag_acc;
  logic [ValueBits-1:0] signed_mag;

  // Character classes.
  always_comb begin
    is_digit = rx_byte inside {[8'h30:8'h39]};
    is_alpha = rx_byte inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    is_note  = rx_byte inside {8'h70, 8'h76, 8'h72, 8'h68, 8'h66, 8'h74, 8'h77, 8'h78};
    is_ctl   = (rx_byte == start_ctl_byte) || (rx_byte == stop_ctl_byte);
  end

  // Signed number as reported, sign extended or truncated to the port width.
  always_comb begin
    signed_mag = cur.is_negative ? (~cur.magnitude + 1'b1) : cur.magnitude;
  end

  // Phase transition, accumulator update and reply generation.
  always_comb begin
    nxt        = cur;
    done       = 1'b0;
    reply      = '0;
    mag_base   = cur.magnitude;
    mag_acc    = '0;

    if (!is_ctl) begin
      case (cur.phase)
        PhNum: begin
          if (is_digit) begin
            nxt.phase = PhNum;
          end else if (rx_byte == ChCr) begin
            nxt.phase = PhTerm;
          end else begin
            nxt.phase = PhUnexp;
          end
        end
        PhAck: begin
          if (rx_byte == ChK) begin
            nxt.phase = PhAck;
          end else if (rx_byte == ChCr) begin
            nxt.phase = PhTerm;
          end else begin
            nxt.phase = PhUnexp;
          end
        end
        PhText: begin
          nxt.phase = (rx_byte == ChCr) ? PhTerm : PhText;
        end
        PhNote: begin
          nxt.phase = (rx_byte == ChCr) ? PhTerm : PhUnexp;
        end
        PhTerm: begin
          if (rx_byte == ChLf) begin
            nxt.phase = PhIdle;
            done      = 1'b1;
          end else begin
            nxt.phase = PhUnexp;
          end
        end
        default: begin
          // Start of a reply, from idle or after a grammar error.
          if (rx_byte == ChO) begin
            nxt.phase        = PhAck;
            nxt.pending_kind = KindAck;
          end else if (is_note) begin
            nxt.phase         = PhNote;
            nxt.pending_kind  = KindNote;
            nxt.notify_letter = rx_byte;
          end else if (is_digit || rx_byte == ChMinus) begin
            nxt.phase        = PhNum;
            nxt.pending_kind = KindNum;
            nxt.is_negative  = 1'b0;
            mag_base         = '0;
          end else if (is_alpha) begin
            nxt.phase        = PhText;
            nxt.pending_kind = KindText;
          end else if (rx_byte == ChCr || rx_byte == ChLf) begin
            nxt.phase = PhIdle;
          end else begin
            nxt.phase = PhUnexp;
          end
        end
      endcase

      // Value times ten plus the digit, as two shifted adds.
      mag_acc = (mag_base << 3) + (mag_base << 1) + ValueBits'(rx_byte[3:0]);

      if (done) begin
        reply.kind = cur.pending_kind;
        if (cur.resync_pending) begin
          nxt.resync_pending = 1'b0;
          reply.lost         = 1'b1;
        end else if (cur.pending_kind == KindNote) begin
          reply.value = ReplyBits'(cur.notify_letter);
        end else if (cur.pending_kind == KindNum) begin
          reply.value = ReplyBits'(signed'(signed_mag));
        end
      end else if (nxt.phase == PhNum) begin
        nxt.magnitude = mag_base;
        if (rx_byte == ChMinus) begin
          nxt.is_negative = 1'b1;
        end
        if (is_digit) begin
          nxt.magnitude = mag_acc;
        end
      end else if (nxt.phase == PhIdle || nxt.phase == PhUnexp) begin
        if (nxt.phase == PhUnexp) begin
          nxt.resync_pending = 1'b1;
        end
        nxt.magnitude = '0;
      end
    end
  end

endmodule

// ----- rtl/motor_reply_line_parser_core.sv -----
// Channel   Direction  Signals                                  Moves
// input     in         in_valid, in_ready, rx_byte              one received byte per request
// output    out        out_valid, out_ready, reply_kind,        one completed reply per request
//                      reply_value, reply_lost
// config    in         cfg_valid, cfg_ready, cfg_index,         one register write per request
//                      cfg_data
//
// One byte is taken every cycle while in_ready is high; it waits in the input register and is
// parsed on its way into the reply register, so a reply appears once its LF byte has passed both
// registers. The per-byte work is the phase decode plus a times-ten accumulate, both combinational.
// Reset (synchronous) clears the parser state and restores the flow-control bytes.
// A stalled output holds the reply register and the input register; in_ready drops
// only while both are full.
module motor_reply_line_parser_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         rx_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output mrlp_pkg::kind_t                    reply_kind,
  output logic signed [mrlp_pkg::ReplyBits-1:0] reply_value,
  output logic                               reply_lost,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [7:0]                         cfg_data
);
  import mrlp_pkg::*;

  logic         byte_valid;
  logic [7:0]   byte_reg;
  logic         advance;
  logic [7:0]   start_ctl_byte;
  logic [7:0]   stop_ctl_byte;
  parse_state_t state;
  parse_state_t state_next;
  logic         step_done;
  reply_t       step_reply;
  reply_t       reply_reg;

  // The input register moves on whenever the reply register can take a result.
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !byte_valid || advance;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_ctl_byte <= StartCtlReset;
      stop_ctl_byte  <= StopCtlReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgStartCtl: start_ctl_byte <= cfg_data;
        CfgStopCtl:  stop_ctl_byte  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_reg <= rx_byte;
    end
  end

  // Parser step for the registered byte.
  mrlp_step u_step (
    .cur            (state),
    .rx_byte        (byte_reg),
    .start_ctl_byte (start_ctl_byte),
    .stop_ctl_byte  (stop_ctl_byte),
    .nxt            (state_next),
    .done           (step_done),
    .reply          (step_reply)
  );

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase          <= PhIdle;
      state.pending_kind   <= KindAck;
      state.notify_letter  <= '0;
      state.magnitude      <= '0;
      state.is_negative    <= 1'b0;
      state.resync_pending <= 1'b0;
    end else if (byte_valid && advance) begin
      state <= state_next;
    end
  end

  // Reply register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= byte_valid && step_done;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && byte_valid && step_done) begin
      reply_reg <= step_reply;
    end
  end

  assign reply_kind  = reply_reg.kind;
  assign reply_value = signed'(reply_reg.value);
  assign reply_lost  = reply_reg.lost;

endmodule

// ----- tb/motor_reply_line_parser_core_tb.sv -----
`timescale 1ns / 1ps

module motor_reply_line_parser_core_tb;
  import mrlp_pkg::*;

  // Cycles without any accepted request before the run is abandoned.
  localparam int StallLimit = 2000;
  localparam int PhaseCount = 8;
  localparam int LineRows = 7;

  // One directed line, with its reply typed in where it is obvious.
  typedef struct packed {
    logic [0:5][7:0] chars;
    logic [2:0]      len;
    logic            pinned;
    kind_t           kind;
    logic [31:0]     value;
    logic            lost;
  } line_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  kind_t                 reply_kind;
  logic signed [ReplyBits-1:0] reply_value;
  logic                  reply_lost;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = CfgStartCtl;
  logic [7:0]            cfg_data = 8'h00;

  // Directed row that the byte on rx_byte belongs to; -1 for random traffic.
  int                    cur_row = -1;

  // Parser state as the testbench expects it to be.
  phase_t                line_phase;
  kind_t                 line_kind;
  logic [7:0]            note_char;
  logic [ValueBits-1:0]  acc_mag;
  logic                  acc_neg;
  logic                  resync_mark;
  logic [7:0]            skip_a;
  logic [7:0]            skip_b;

  reply_t                replies_due[$];
  logic [7:0]            line_chars[$];
  line_row_t             lines[LineRows];
  logic [7:0]            first_skip[PhaseCount];
  logic [7:0]            second_skip[PhaseCount];
  int                    phase_quota[PhaseCount];

  string note_letters = "pvrhftwx";
  string big_numbers[6] = '{"2147483647", "2147483648", "4294967295", "4294967296",
                            "99999999999", "0"};

  bit                    steady = 1'b0;
  int                    chars_sent = 0;
  int                    replies_seen = 0;
  int                    lost_seen = 0;
  int                    mismatches = 0;
  int                    idle_cycles = 0;
  int                    settings_used = 0;

  motor_reply_line_parser_core DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .reply_kind (reply_kind),
    .reply_value(reply_value),
    .reply_lost (reply_lost),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advances the expected parser state by one byte; returns 1 when a reply completes.
  function automatic bit parse_reply_byte(input logic [7:0] c, output reply_t r);
    phase_t nxt;
    bit     fin;
    r = '0;
    fin = 1'b0;
    // Flow-control bytes are dropped before anything else looks at them.
    if (c == skip_a || c == skip_b) return 1'b0;
    nxt = PhUnexp;
    case (line_phase)
      PhNum: begin
        if (c inside {["0":"9"]}) nxt = PhNum;
        else if (c == ChCr) nxt = PhTerm;
      end
      PhAck: begin
        if (c == ChK) nxt = PhAck;
        else if (c == ChCr) nxt = PhTerm;
      end
      PhText: nxt = (c == ChCr) ? PhTerm : PhText;
      PhNote: begin
        if (c == ChCr) nxt = PhTerm;
      end
      PhTerm: begin
        if (c == ChLf) begin
          nxt = PhIdle;
          fin = 1'b1;
        end
      end
      default: begin
        // The first character of a line decides what kind of reply it is.
        if (c == ChO) begin
          nxt = PhAck;
          line_kind = KindAck;
        end else if (c inside {"p", "v", "r", "h", "f", "t", "w", "x"}) begin
          nxt = PhNote;
          line_kind = KindNote;
          note_char = c;
        end else if (c inside {["0":"9"]} || c == ChMinus) begin
          nxt = PhNum;
          line_kind = KindNum;
          acc_mag = '0;
          acc_neg = 1'b0;
        end else if (c inside {["a":"z"], ["A":"Z"]}) begin
          nxt = PhText;
          line_kind = KindText;
        end else if (c == ChCr || c == ChLf) begin
          nxt = PhIdle;
        end
      end
    endcase
    line_phase = nxt;

    if (fin) begin
      r.kind = line_kind;
      if (resync_mark) begin
        // A reply completing after a grammar error is dropped with a zero value.
        resync_mark = 1'b0;
        r.lost = 1'b1;
      end else if (line_kind == KindNote) begin
        r.value = {24'd0, note_char};
      end else if (line_kind == KindNum) begin
        r.value = acc_neg ? -acc_mag : acc_mag;
      end
      return 1'b1;
    end

    if (nxt == PhNum) begin
      if (c == ChMinus) acc_neg = 1'b1;
      if (c inside {["0":"9"]}) acc_mag = acc_mag * ValueBits'(10) + ValueBits'(c - "0");
    end else if (nxt == PhIdle || nxt == PhUnexp) begin
      if (nxt == PhUnexp) resync_mark = 1'b1;
      acc_mag = '0;
    end
    return 1'b0;
  endfunction

  // Appends a character, now and then preceded by one of the flow-control bytes.
  function automatic void put(input logic [7:0] c);
    if ($urandom_range(0, 11) == 0) line_chars.push_back($urandom_range(0, 1) ? skip_a : skip_b);
    line_chars.push_back(c);
  endfunction

  // Builds one line of random traffic: mostly well-formed replies, some noise.
  function automatic void compose_line();
    int    pick;
    int    n;
    bit    minus;
    string digits;
    line_chars.delete();
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      n = $urandom_range(1, 4);
      repeat (n) put(8'($urandom_range(0, 255)));
      return;
    end
    if (pick < 28) begin
      put(ChO);
      n = $urandom_range(0, 3);
      repeat (n) put(ChK);
    end else if (pick < 46) begin
      put(note_letters[$urandom_range(0, 7)]);
    end else if (pick < 76) begin
      minus = ($urandom_range(0, 3) == 0);
      if (minus) put(ChMinus);
      if ($urandom_range(0, 7) == 0) begin
        digits = big_numbers[$urandom_range(0, 5)];
        for (int i = 0; i < digits.len(); i++) put(digits[i]);
      end else begin
        n = $urandom_range(minus ? 0 : 1, 10);
        repeat (n) put("0" + 8'($urandom_range(0, 9)));
      end
    end else begin
      put($urandom_range(0, 1) ? "A" + 8'($urandom_range(0, 25)) : "a" + 8'($urandom_range(0, 25)));
      n = $urandom_range(0, 6);
      repeat (n) begin
        digits = "";
        pick = $urandom_range(0, 255);
        put((pick == ChCr) ? "e" : 8'(pick));
      end
    end
    // Most lines end properly; a few carry a stray byte or lose half the terminator.
    case ($urandom_range(0, 19))
      0: begin
        line_chars.insert($urandom_range(0, line_chars.size()), 8'($urandom_range(0, 255)));
        put(ChCr);
        put(ChLf);
      end
      1: put(ChCr);
      2: put(ChLf);
      default: begin
        put(ChCr);
        put(ChLf);
      end
    endcase
  endfunction

  // Offers one byte, after a random gap unless steady is set, and holds it until the request is taken.
  task automatic send_char(input logic [7:0] c, input int row);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= c;
    cur_row <= row;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  // Stops the input and waits until every expected reply has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Writes both flow-control bytes, keeping the write request up in between.
  task automatic load_skip_bytes(input logic [7:0] first, input logic [7:0] second);
    cfg_valid <= 1'b1;
    cfg_index <= CfgStartCtl;
    cfg_data <= first;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CfgStopCtl;
    cfg_data <= second;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch on reply %0d, %s: expected %0d, got %0d",
               replies_seen, what, $signed(want), $signed(got));
  endtask

  // The receiver stalls for a random number of cycles before each reply, unless steady is set.
  initial begin
    int hold;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 15);
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Follows every accepted request: predicts on bytes, checks on replies.
  always @(posedge clk) begin : reply_checker
    reply_t guess;
    reply_t due;
    bit     took;
    if (!rst) begin
      took = 1'b0;
      if (cfg_valid && cfg_ready) begin
        took = 1'b1;
        case (cfg_index)
          CfgStartCtl: skip_a = cfg_data;
          CfgStopCtl:  skip_b = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        took = 1'b1;
        if (parse_reply_byte(rx_byte, guess)) begin
          if (cur_row >= 0 && lines[cur_row].pinned) begin
            guess.kind = lines[cur_row].kind;
            guess.value = lines[cur_row].value;
            guess.lost = lines[cur_row].lost;
          end
          replies_due.push_back(guess);
        end
      end
      if (out_valid && out_ready) begin
        took = 1'b1;
        replies_seen++;
        if (reply_lost) lost_seen++;
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Reply %0d arrived with nothing expected: kind %0d value %0d lost %0d",
                     replies_seen, reply_kind, reply_value, reply_lost);
        end else begin
          due = replies_due.pop_front();
          if (reply_kind !== due.kind) flag_mismatch("kind", 32'(due.kind), 32'(reply_kind));
          if (reply_value !== due.value) flag_mismatch("value", due.value, reply_value);
          if (reply_lost !== due.lost) flag_mismatch("lost flag", 32'(due.lost), 32'(reply_lost));
        end
      end
      if (took) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("Watchdog: no request accepted for %0d cycles", StallLimit);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int start;
    // Expected state after reset.
    line_phase = PhIdle;
    line_kind = KindAck;
    note_char = 8'h00;
    acc_mag = '0;
    acc_neg = 1'b0;
    resync_mark = 1'b0;
    skip_a = StartCtlReset;
    skip_b = StopCtlReset;

    // Directed lines: every reply kind, both byte extremes and the corner cases.
    lines[0] = '{{"OK", ChCr, ChLf, 16'h0}, 3'd4, 1'b1, KindAck, 32'd0, 1'b0};
    lines[1] = '{{"v", ChCr, ChLf, 24'h0}, 3'd3, 1'b1, KindNote, 32'd118, 1'b0};
    // A lone minus sign is a valid number of value zero.
    lines[2] = '{{ChMinus, ChCr, ChLf, 24'h0}, 3'd3, 1'b1, KindNum, 32'd0, 1'b0};
    // A null byte breaks the grammar, so the following reply is lost.
    lines[3] = '{{8'h00, "x", ChCr, ChLf, 16'h0}, 3'd4, 1'b1, KindNote, 32'd0, 1'b1};
    lines[4] = '{{"-12", ChCr, ChLf, 8'h0}, 3'd5, 1'b0, KindAck, 32'd0, 1'b0};
    lines[5] = '{{8'hFF, "7", ChCr, ChLf, 16'h0}, 3'd4, 1'b1, KindNum, 32'd0, 1'b1};
    // Flow-control bytes and an idle LF vanish without effect.
    lines[6] = '{{StopCtlReset, ChLf, "A", ChCr, StartCtlReset, ChLf}, 3'd6, 1'b1,
                 KindText, 32'd0, 1'b0};

    // Flow-control settings per phase; the CR/LF phase can never finish a reply.
    first_skip  = '{8'h00, ChO, ChCr, "t", 8'hFF, 8'h00, 8'h00, StartCtlReset};
    second_skip = '{8'hFF, "5", ChLf, "a", 8'h00, 8'h00, 8'h00, StopCtlReset};
    phase_quota = '{260, 260, 40, 260, 260, 260, 260, 260};
    first_skip[5] = 8'($urandom_range(0, 255));
    second_skip[5] = 8'($urandom_range(0, 255));
    first_skip[6] = 8'($urandom_range(0, 255));
    second_skip[6] = 8'($urandom_range(0, 255));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < LineRows; i++)
      for (int k = 0; k < lines[i].len; k++) send_char(lines[i].chars[k], i);

    // Random traffic under each flow-control setting in turn.
    for (int p = 0; p < PhaseCount; p++) begin
      settle();
      load_skip_bytes(first_skip[p], second_skip[p]);
      settings_used++;
      start = chars_sent;
      while (chars_sent - start < phase_quota[p]) begin
        compose_line();
        if ($urandom_range(0, 15) == 0) steady = !steady;
        foreach (line_chars[k]) send_char(line_chars[k], -1);
      end
    end
    settle();

    $display("Sent %0d bytes under %0d flow-control settings after the defaults.",
             chars_sent, settings_used);
    $display("Checked %0d replies, %0d of them dropped for resync; %0d mismatches.",
             replies_seen, lost_seen, mismatches);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
